// ===== rtl/dlrs_pkg.sv =====
// Package for the decimal LSD radix sorter.
// Holds widths, depths, state codes and the stored entry type.
// No dependencies.
`timescale 1ns / 1ps
package dlrs_pkg;

    localparam int KEY_BITS   = 31;
    localparam int MAX_KEYS   = 64;
    localparam int ADDR_BITS  = $clog2(MAX_KEYS);
    localparam int FILL_BITS  = $clog2(MAX_KEYS + 1);
    // Decimal digits needed for the largest KEY_BITS-bit key.
    localparam int DEC_DIGITS = 10;
    localparam int DIG_BITS   = 4;
    localparam int BCD_BITS   = DEC_DIGITS * DIG_BITS;
    localparam int PASS_BITS  = $clog2(DEC_DIGITS + 1);
    localparam int CNT_BITS   = $clog2(MAX_KEYS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CONV   = 4'd1;
    localparam logic [3:0] S_COUNT  = 4'd2;
    localparam logic [3:0] S_PREFIX = 4'd3;
    localparam logic [3:0] S_SCAT   = 4'd4;
    localparam logic [3:0] S_COPY   = 4'd5;
    localparam logic [3:0] S_EMRD   = 4'd6;
    localparam logic [3:0] S_EMLD   = 4'd7;
    localparam logic [3:0] S_EMWT   = 4'd8;

    // A stored key together with its decimal digits.
    typedef struct packed {
        logic [BCD_BITS-1:0] bcd;
        logic [KEY_BITS-1:0] key;
    } entry_t;

endpackage

// ===== rtl/dlrs_in_if.sv =====
// Input channel of the decimal LSD radix sorter.
// Depends on dlrs_pkg.
`timescale 1ns / 1ps
interface dlrs_in_if
    import dlrs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] key;
    logic                last_key;

    modport source (output valid, output key, output last_key, input ready);
    modport sink (input valid, input key, input last_key, output ready);
endinterface

// ===== rtl/dlrs_out_if.sv =====
// Output channel of the decimal LSD radix sorter.
// Depends on dlrs_pkg.
`timescale 1ns / 1ps
interface dlrs_out_if
    import dlrs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] sorted_key;
    logic                last_sorted;

    modport source (output valid, output sorted_key, output last_sorted, input ready);
    modport sink (input valid, input sorted_key, input last_sorted, output ready);
endinterface

// ===== rtl/decimal_lsd_radix_sorter_top.sv =====
// Decimal LSD radix sorter: loads a block of keys, sorts them, emits them.
// Depends on dlrs_pkg, dlrs_in_if and dlrs_out_if.
//
//   channel  | dir | payload
//   keys     | in  | key, last_key
//   sorted   | out | sorted_key, last_sorted
//
// Each key is loaded through a 31-step binary to decimal conversion.
// A closing key starts up to ten passes over the block; each pass counts the
// digits, forms prefix sums, scatters the keys and copies them back.
// Each sorted key passes a read, a load and a wait state, plus any output stall.
// Reset clears control only; memories need no clearing. No key is taken
// while a block is being sorted or emitted.
`timescale 1ns / 1ps
module decimal_lsd_radix_sorter_top
    import dlrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dlrs_in_if.sink     keys,
    dlrs_out_if.source  sorted
);

    entry_t key_mem  [MAX_KEYS];
    entry_t scat_mem [MAX_KEYS];

    logic [3:0]           state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 vld_reg, vld_next;
    logic [ADDR_BITS-1:0] addr_d_reg, addr_d_next;
    logic [PASS_BITS-1:0] pass_reg, pass_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic [KEY_BITS-1:0]  largest_reg, largest_next;
    logic [BCD_BITS-1:0]  lbcd_reg, lbcd_next;
    logic [6:0]           dcnt_reg [DEC_DIGITS];
    logic [6:0]           dcnt_next [DEC_DIGITS];
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [KEY_BITS-1:0]  bin_reg, bin_next;
    logic [BCD_BITS-1:0]  bcd_reg, bcd_next;
    logic                 last_reg, last_next;
    logic                 ovalid_reg, ovalid_next;
    logic [KEY_BITS-1:0]  okey_reg, okey_next;
    logic                 olast_reg, olast_next;

    logic [ADDR_BITS-1:0] key_raddr, scat_raddr, key_waddr, scat_waddr;
    logic                 key_we, scat_we;
    entry_t               key_wdata, scat_wdata, key_rdata_reg, scat_rdata_reg;
    logic [BCD_BITS-1:0]  bcd_adj;
    logic [PASS_BITS-1:0] npass;
    logic [DIG_BITS-1:0]  digit;
    logic [6:0]           dec_val;
    logic [CNT_BITS-1:0]  back_idx;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rdata_reg <= key_mem[key_raddr];
        if (scat_we)
        begin
            scat_mem[scat_waddr] <= scat_wdata;
        end
        scat_rdata_reg <= scat_mem[scat_raddr];
    end

    // Digits of the largest key decide how many passes run.
    always_comb
    begin
        npass = '0;
        for (int d = 0; d < DEC_DIGITS; d++)
        begin
            if (lbcd_reg[d*DIG_BITS +: DIG_BITS] != '0)
            begin
                npass = PASS_BITS'(d + 1);
            end
        end
    end

    always_comb
    begin
        for (int d = 0; d < DEC_DIGITS; d++)
        begin
            if (bcd_reg[d*DIG_BITS +: DIG_BITS] >= 4'd5)
            begin
                bcd_adj[d*DIG_BITS +: DIG_BITS] = bcd_reg[d*DIG_BITS +: DIG_BITS] + 4'd3;
            end
            else
            begin
                bcd_adj[d*DIG_BITS +: DIG_BITS] = bcd_reg[d*DIG_BITS +: DIG_BITS];
            end
        end
    end

    assign digit    = key_rdata_reg.bcd[pass_reg*DIG_BITS +: DIG_BITS];
    assign dec_val  = dcnt_reg[digit] - 7'd1;
    assign back_idx = fill_reg - CNT_BITS'(1) - cnt_reg;

    assign keys.ready         = (state_reg == S_IDLE);
    assign sorted.valid       = ovalid_reg;
    assign sorted.sorted_key  = okey_reg;
    assign sorted.last_sorted = olast_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        vld_next     = 1'b0;
        addr_d_next  = addr_d_reg;
        pass_next    = pass_reg;
        fill_next    = fill_reg;
        largest_next = largest_reg;
        lbcd_next    = lbcd_reg;
        dcnt_next    = dcnt_reg;
        key_next     = key_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        last_next    = last_reg;
        ovalid_next  = ovalid_reg;
        okey_next    = okey_reg;
        olast_next   = olast_reg;
        key_raddr    = cnt_reg[ADDR_BITS-1:0];
        scat_raddr   = cnt_reg[ADDR_BITS-1:0];
        key_we       = 1'b0;
        key_waddr    = fill_reg[ADDR_BITS-1:0];
        key_wdata    = '{bcd: bcd_reg, key: key_reg};
        scat_we      = 1'b0;
        scat_waddr   = dec_val[ADDR_BITS-1:0];
        scat_wdata   = key_rdata_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (keys.valid)
                begin
                    key_next   = keys.key;
                    bin_next   = keys.key;
                    bcd_next   = '0;
                    last_next  = keys.last_key;
                    cnt_next   = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (cnt_reg == CNT_BITS'(KEY_BITS))
                begin
                    if (fill_reg < FILL_BITS'(MAX_KEYS))
                    begin
                        key_we    = 1'b1;
                        fill_next = fill_reg + FILL_BITS'(1);
                        if (key_reg > largest_reg)
                        begin
                            largest_next = key_reg;
                            lbcd_next    = bcd_reg;
                        end
                    end
                    cnt_next = '0;
                    if (!last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Pass count must reflect the key just stored.
                        pass_next = '0;
                        for (int d = 0; d < DEC_DIGITS; d++)
                        begin
                            dcnt_next[d] = '0;
                        end
                        state_next = S_COUNT;
                    end
                end
                else
                begin
                    {bcd_next, bin_next} = {bcd_adj, bin_reg} << 1;
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end
            S_COUNT:
            begin
                if (cnt_reg == '0 && !vld_reg && npass == '0)
                begin
                    state_next = S_EMRD;
                end
                else
                begin
                    if (vld_reg)
                    begin
                        dcnt_next[digit] = dcnt_reg[digit] + 7'd1;
                    end
                    if (cnt_reg < fill_reg)
                    begin
                        cnt_next = cnt_reg + CNT_BITS'(1);
                        vld_next = 1'b1;
                    end
                    else if (!vld_reg)
                    begin
                        cnt_next   = CNT_BITS'(1);
                        state_next = S_PREFIX;
                    end
                end
            end
            S_PREFIX:
            begin
                dcnt_next[cnt_reg[DIG_BITS-1:0]] = dcnt_reg[cnt_reg[DIG_BITS-1:0]]
                    + dcnt_reg[cnt_reg[DIG_BITS-1:0] - DIG_BITS'(1)];
                if (cnt_reg == CNT_BITS'(DEC_DIGITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_SCAT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end
            S_SCAT:
            begin
                // Keys are read from the back so equal digits keep their order.
                key_raddr = back_idx[ADDR_BITS-1:0];
                if (vld_reg)
                begin
                    dcnt_next[digit] = dec_val;
                    scat_we          = 1'b1;
                end
                if (cnt_reg < fill_reg)
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                    vld_next = 1'b1;
                end
                else if (!vld_reg)
                begin
                    cnt_next   = '0;
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                key_waddr = addr_d_reg;
                key_wdata = scat_rdata_reg;
                key_we    = vld_reg;
                if (cnt_reg < fill_reg)
                begin
                    addr_d_next = cnt_reg[ADDR_BITS-1:0];
                    cnt_next    = cnt_reg + CNT_BITS'(1);
                    vld_next    = 1'b1;
                end
                else if (!vld_reg)
                begin
                    cnt_next = '0;
                    for (int d = 0; d < DEC_DIGITS; d++)
                    begin
                        dcnt_next[d] = '0;
                    end
                    if (pass_reg + PASS_BITS'(1) == npass)
                    begin
                        state_next = S_EMRD;
                    end
                    else
                    begin
                        pass_next  = pass_reg + PASS_BITS'(1);
                        state_next = S_COUNT;
                    end
                end
            end
            S_EMRD:
            begin
                state_next = S_EMLD;
            end
            S_EMLD:
            begin
                okey_next   = key_rdata_reg.key;
                olast_next  = (cnt_reg == fill_reg - CNT_BITS'(1));
                ovalid_next = 1'b1;
                state_next  = S_EMWT;
            end
            S_EMWT:
            begin
                if (sorted.ready)
                begin
                    ovalid_next = 1'b0;
                    if (olast_reg)
                    begin
                        fill_next    = '0;
                        largest_next = '0;
                        lbcd_next    = '0;
                        cnt_next     = '0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CNT_BITS'(1);
                        state_next = S_EMRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            vld_reg     <= 1'b0;
            pass_reg    <= '0;
            fill_reg    <= '0;
            largest_reg <= '0;
            lbcd_reg    <= '0;
            ovalid_reg  <= 1'b0;
            for (int d = 0; d < DEC_DIGITS; d++)
            begin
                dcnt_reg[d] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            vld_reg     <= vld_next;
            pass_reg    <= pass_next;
            fill_reg    <= fill_next;
            largest_reg <= largest_next;
            lbcd_reg    <= lbcd_next;
            ovalid_reg  <= ovalid_next;
            dcnt_reg    <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_d_reg <= addr_d_next;
        key_reg    <= key_next;
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        last_reg   <= last_next;
        okey_reg   <= okey_next;
        olast_reg  <= olast_next;
    end

endmodule

// ===== bench/decimal_lsd_radix_sorter_top_test.sv =====
// Self-checking bench for the decimal LSD radix sorter top level.
// Depends on dlrs_pkg, dlrs_in_if, dlrs_out_if and decimal_lsd_radix_sorter_top.
`timescale 1ns / 1ps
module decimal_lsd_radix_sorter_top_test;
    import dlrs_pkg::*;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                last;
    } key_item_t;

    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;

    dlrs_in_if  keys ();
    dlrs_out_if sorted ();

    decimal_lsd_radix_sorter_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys.sink),
        .sorted (sorted.source)
    );

    key_item_t pending_keys[$];
    key_item_t sorted_expect[$];
    logic [KEY_BITS-1:0] group_keys[$];

    int  errors = 0;
    int  cycles = 0;
    int  keys_sent = 0;
    int  keys_seen = 0;
    int  groups_done = 0;
    bit  send_paused = 1'b0;
    bit  calm = 1'b0;
    bit  hold_request = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left;

    // Stable base-10 LSD sort of the open group, then queue the expected keys.
    task automatic predict_sorted_group();
        logic [KEY_BITS-1:0] work[$];
        logic [KEY_BITS-1:0] scratch[MAX_KEYS];
        logic [KEY_BITS-1:0] biggest;
        longint unsigned     weight;
        int                  tally[10];
        int                  n;
        int                  d;
        work = group_keys;
        n = work.size();
        biggest = 0;
        foreach (work[i])
            if (work[i] > biggest)
                biggest = work[i];
        weight = 1;
        while (longint'(biggest) / weight > 0)
        begin
            for (int j = 0; j < 10; j++)
                tally[j] = 0;
            for (int i = 0; i < n; i++)
                tally[(longint'(work[i]) / weight) % 10]++;
            for (int j = 1; j < 10; j++)
                tally[j] += tally[j - 1];
            for (int i = n - 1; i >= 0; i--)
            begin
                d = (longint'(work[i]) / weight) % 10;
                tally[d]--;
                scratch[tally[d]] = work[i];
            end
            for (int i = 0; i < n; i++)
                work[i] = scratch[i];
            weight = weight * 10;
        end
        for (int i = 0; i < n; i++)
            sorted_expect.push_back('{key: work[i], last: (i == n - 1)});
        group_keys.delete();
    endtask

    // The store keeps at most MAX_KEYS keys; later keys of the group are dropped.
    task automatic accept_key(input key_item_t it);
        if (group_keys.size() < MAX_KEYS)
            group_keys.push_back(it.key);
        if (it.last)
            predict_sorted_group();
    endtask

    task automatic queue_group(input int n, input int style);
        key_item_t it;
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0: it.key = KEY_BITS'($urandom_range(0, 999));
                1: it.key = KEY_BITS'($urandom);
                2: it.key = KEY_BITS'($urandom_range(0, 9) * (10 ** $urandom_range(0, 8)));
                default: it.key = KEY_BITS'($urandom_range(0, 3));
            endcase
            it.last = (i == n - 1);
            pending_keys.push_back(it);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Source side driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys.valid    <= 1'b0;
            keys.key      <= '0;
            keys.last_key <= 1'b0;
        end
        else
        begin
            if (keys.valid && keys.ready)
            begin
                accept_key('{key: keys.key, last: keys.last_key});
                keys_sent++;
            end
            if ((!keys.valid || keys.ready) )
            begin
                if (pending_keys.size() > 0 && !send_paused
                    && (calm || $urandom_range(0, 99) >= 33))
                begin
                    keys.valid    <= 1'b1;
                    keys.key      <= pending_keys[0].key;
                    keys.last_key <= pending_keys[0].last;
                    void'(pending_keys.pop_front());
                end
                else
                    keys.valid <= 1'b0;
            end
        end
    end

    // Sink side monitor and checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted.ready <= 1'b0;
            hold_left    = 0;
        end
        else
        begin
            if (sorted.valid && sorted.ready)
            begin
                keys_seen++;
                if (sorted_expect.size() == 0)
                begin
                    $error("unexpected transfer: sorted_key %0d", sorted.sorted_key);
                    errors++;
                end
                else
                begin
                    if (sorted.sorted_key !== sorted_expect[0].key)
                    begin
                        $error("sorted_key: expected %0d, actual %0d",
                               sorted_expect[0].key, sorted.sorted_key);
                        errors++;
                    end
                    if (sorted.last_sorted !== sorted_expect[0].last)
                    begin
                        $error("last_sorted: expected %0d, actual %0d",
                               sorted_expect[0].last, sorted.last_sorted);
                        errors++;
                    end
                    if (sorted_expect[0].last)
                        groups_done++;
                    void'(sorted_expect.pop_front());
                end
            end
            if (hold_request && !hold_taken)
            begin
                hold_left  = 3000;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                sorted.ready <= 1'b0;
            end
            else
                sorted.ready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("decimal_lsd_radix_sorter_top regression: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_keys.size() > 0 || keys.valid || sorted_expect.size() > 0
               || group_keys.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        int        n;
        @(posedge rst_n);

        // Directed: single key, extremes, all-zero group, equal keys, ties.
        pending_keys.push_back('{key: 0, last: 1});
        pending_keys.push_back('{key: {KEY_BITS{1'b1}}, last: 1});
        pending_keys.push_back('{key: 0, last: 0});
        pending_keys.push_back('{key: 0, last: 0});
        pending_keys.push_back('{key: 0, last: 1});
        pending_keys.push_back('{key: {KEY_BITS{1'b1}}, last: 0});
        pending_keys.push_back('{key: 0, last: 0});
        pending_keys.push_back('{key: 1000000000, last: 0});
        pending_keys.push_back('{key: 999999999, last: 0});
        pending_keys.push_back('{key: 'h2AAAAAAA, last: 0});
        pending_keys.push_back('{key: 'h55555555, last: 0});
        pending_keys.push_back('{key: 10, last: 0});
        pending_keys.push_back('{key: 9, last: 1});
        pending_keys.push_back('{key: 7, last: 0});
        pending_keys.push_back('{key: 7, last: 0});
        pending_keys.push_back('{key: 70, last: 1});
        wait_drained();

        // Overflowing group: the keys beyond the store size are dropped.
        queue_group(MAX_KEYS + 3, 1);
        wait_drained();

        // The receiver holds off while the sender keeps offering keys.
        hold_request = 1'b1;
        queue_group(20, 0);
        queue_group(12, 1);
        wait_drained();

        // Random groups, mostly small, one stretch with no idling.
        for (int g = 0; g < 10; g++)
        begin
            calm = (g >= 4 && g < 8);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MAX_KEYS)
                                             : $urandom_range(1, 8);
            queue_group(n, $urandom_range(0, 3));
            if (g % 4 == 3)
            begin
                // The sender pauses until every expected key has come.
                while (pending_keys.size() > 0 || keys.valid)
                    @(posedge clk);
                send_paused = 1'b1;
                while (sorted_expect.size() > 0 || group_keys.size() > 0)
                    @(posedge clk);
                send_paused = 1'b0;
            end
        end
        calm = 0;
        wait_drained();

        $display("Sent %0d keys in %0d groups and checked %0d sorted keys.",
                 keys_sent, groups_done, keys_seen);
        if (errors == 0)
            $display("decimal_lsd_radix_sorter_top regression: pass");
        else
            $display("decimal_lsd_radix_sorter_top regression: fail");
        $finish;
    end
endmodule
